// ===== rtl/hci_pkg.sv =====
// ----------------------------------------------------------------------------
// hci_pkg
// Shared constants, correction grid and types for the humidity correction
// interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package hci_pkg;

    // default grid size and size of the stored grid
    localparam int ALT_ROWS_DEF = 6;
    localparam int DEW_COLS_DEF = 30;
    localparam int ROM_ROWS     = 6;
    localparam int ROM_COLS     = 30;

    // field and bus widths
    localparam int DEW_W     = 15;
    localparam int ALT_W     = 15;
    localparam int OUT_W     = 16;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 16;

    // dew-point axis: 1/128 C units, column step of 2 C is 256 units
    localparam int DEW_BASE  = -3584;
    localparam int DEW_SHIFT = 8;
    localparam int DEW_STEP  = 256;

    // altitude axis: metres, row step 500, quotient by reciprocal
    localparam int ALT_STEP        = 500;
    localparam int ALT_RECIP       = 16778;
    localparam int ALT_RECIP_SHIFT = 23;

    // in-cell offset width and grid entry width
    localparam int OFF_W   = 16;
    localparam int ENTRY_W = 7;

    // blend accumulator and output scaling
    localparam int ACC_W       = 42;
    localparam int BASE_SCALE  = DEW_STEP * ALT_STEP;
    localparam int ROUND_BIAS  = 640;
    localparam int ROUND_SHIFT = 8;
    localparam int QUOT_LIMIT  = 65535 * 5 + 4;
    localparam int DIV5_RECIP  = 838861;
    localparam int DIV5_SHIFT  = 22;
    localparam int OUT_MAX     = 65535;

    // pipeline depth from input register to output register
    localparam int NUM_STAGES = 10;

    typedef logic [ENTRY_W-1:0] entry_t;

    // four corners of one grid cell
    typedef struct packed {
        entry_t c00;
        entry_t c10;
        entry_t c01;
        entry_t c11;
    } corner_t;

    // correction grid in tenths of a degree, row-major by altitude
    localparam entry_t GRID [0:ROM_ROWS*ROM_COLS-1] = '{
        7'd1, 7'd1, 7'd1, 7'd1, 7'd1, 7'd1, 7'd2, 7'd2, 7'd2, 7'd3,
        7'd3, 7'd4, 7'd5, 7'd6, 7'd7, 7'd8, 7'd9, 7'd10, 7'd12, 7'd13,
        7'd15, 7'd17, 7'd19, 7'd22, 7'd25, 7'd28, 7'd32, 7'd36, 7'd41, 7'd46,
        7'd1, 7'd1, 7'd1, 7'd1, 7'd1, 7'd2, 7'd2, 7'd2, 7'd3, 7'd3,
        7'd4, 7'd4, 7'd5, 7'd6, 7'd7, 7'd8, 7'd10, 7'd11, 7'd13, 7'd15,
        7'd17, 7'd19, 7'd22, 7'd25, 7'd28, 7'd32, 7'd36, 7'd40, 7'd46, 7'd51,
        7'd1, 7'd1, 7'd1, 7'd1, 7'd1, 7'd2, 7'd2, 7'd2, 7'd3, 7'd4,
        7'd4, 7'd5, 7'd6, 7'd7, 7'd8, 7'd10, 7'd11, 7'd13, 7'd15, 7'd17,
        7'd19, 7'd22, 7'd25, 7'd28, 7'd32, 7'd36, 7'd40, 7'd46, 7'd51, 7'd58,
        7'd1, 7'd1, 7'd1, 7'd1, 7'd2, 7'd2, 7'd2, 7'd3, 7'd3, 7'd4,
        7'd5, 7'd6, 7'd7, 7'd8, 7'd9, 7'd11, 7'd12, 7'd14, 7'd16, 7'd19,
        7'd21, 7'd24, 7'd28, 7'd31, 7'd36, 7'd40, 7'd46, 7'd51, 7'd58, 7'd65,
        7'd1, 7'd1, 7'd1, 7'd1, 7'd2, 7'd2, 7'd3, 7'd3, 7'd4, 7'd5,
        7'd5, 7'd6, 7'd8, 7'd9, 7'd11, 7'd12, 7'd14, 7'd16, 7'd18, 7'd21,
        7'd24, 7'd27, 7'd31, 7'd35, 7'd40, 7'd45, 7'd51, 7'd58, 7'd65, 7'd73,
        7'd1, 7'd1, 7'd1, 7'd2, 7'd2, 7'd2, 7'd3, 7'd4, 7'd4, 7'd5,
        7'd6, 7'd7, 7'd9, 7'd10, 7'd12, 7'd14, 7'd16, 7'd18, 7'd21, 7'd24,
        7'd27, 7'd31, 7'd35, 7'd40, 7'd45, 7'd51, 7'd58, 7'd65, 7'd73, 7'd82
    };

    // grid entry, row and column limited to the stored grid
    function automatic entry_t grid_at(input logic [7:0] row, input logic [7:0] col);
        logic [7:0] r;
        logic [7:0] c;
        logic [7:0] idx;
        r   = (row > 8'(ROM_ROWS - 1)) ? 8'(ROM_ROWS - 1) : row;
        c   = (col > 8'(ROM_COLS - 1)) ? 8'(ROM_COLS - 1) : col;
        idx = 8'(r * 8'(ROM_COLS) + c);
        return GRID[idx];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/hci_cell.sv =====
// ----------------------------------------------------------------------------
// hci_cell
// Cell selection on both axes: input register, column pick and altitude
// quotient, then row pick and in-cell offsets. Three registered stages.
// ----------------------------------------------------------------------------
`default_nettype none

module hci_cell #(
    parameter int ALT_ROWS = hci_pkg::ALT_ROWS_DEF,
    parameter int DEW_COLS = hci_pkg::DEW_COLS_DEF,
    localparam int ALT_IDX_W = $clog2(ALT_ROWS),
    localparam int DEW_IDX_W = $clog2(DEW_COLS)
) (
    input  wire logic                                aclk,
    input  wire logic [2:0]                          en,
    input  wire logic signed [hci_pkg::DEW_W-1:0]    dew_point,
    input  wire logic signed [hci_pkg::ALT_W-1:0]    altitude,
    output logic [ALT_IDX_W-1:0]                     zi,
    output logic [DEW_IDX_W-1:0]                     di,
    output logic signed [hci_pkg::OFF_W-1:0]         dz,
    output logic signed [hci_pkg::OFF_W-1:0]         dd
);

    localparam int PROD_W = hci_pkg::ALT_W - 1 + 15;
    localparam int QUOT_W = PROD_W - hci_pkg::ALT_RECIP_SHIFT;

    // stage one: input register
    logic signed [hci_pkg::DEW_W-1:0] dew_s1_reg;
    logic signed [hci_pkg::ALT_W-1:0] alt_s1_reg;

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            dew_s1_reg <= dew_point;
            alt_s1_reg <= altitude;
        end
    end

    // column pick: floor by shift, limited to the last cell
    logic signed [15:0]         dew_rel;
    logic [6:0]                 dew_idx_raw;
    logic [DEW_IDX_W-1:0]       di_s2_next;
    logic [16:0]                dcell_base;
    logic signed [16:0]         dd_wide;
    logic [hci_pkg::ALT_W-2:0]  alt_pos;
    logic [PROD_W-1:0]          alt_prod_next;

    always_comb begin
        dew_rel     = $signed(16'(dew_s1_reg)) - $signed(16'(hci_pkg::DEW_BASE));
        dew_idx_raw = (dew_rel > 16'sd0) ? dew_rel[14:8] : 7'd0;
        if (8'(dew_idx_raw) > 8'(DEW_COLS - 2)) begin
            di_s2_next = DEW_IDX_W'(DEW_COLS - 2);
        end else begin
            di_s2_next = DEW_IDX_W'(dew_idx_raw);
        end
        dcell_base = 17'(di_s2_next) << hci_pkg::DEW_SHIFT;
        dd_wide    = $signed(17'(dew_rel)) - $signed(dcell_base);
        // altitude quotient by 500 through a reciprocal
        alt_pos       = (alt_s1_reg > 15'sd0) ? alt_s1_reg[hci_pkg::ALT_W-2:0] : '0;
        alt_prod_next = PROD_W'(alt_pos) * PROD_W'(hci_pkg::ALT_RECIP);
    end

    // stage two
    logic [DEW_IDX_W-1:0]             di_s2_reg;
    logic signed [hci_pkg::OFF_W-1:0] dd_s2_reg;
    logic [PROD_W-1:0]                alt_prod_reg;
    logic signed [hci_pkg::ALT_W-1:0] alt_s2_reg;

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            di_s2_reg    <= di_s2_next;
            dd_s2_reg    <= dd_wide[hci_pkg::OFF_W-1:0];
            alt_prod_reg <= alt_prod_next;
            alt_s2_reg   <= alt_s1_reg;
        end
    end

    // row pick and altitude offset
    logic [QUOT_W-1:0]    alt_quot;
    logic [ALT_IDX_W-1:0] zi_next;
    logic [17:0]          rcell_base;
    logic signed [17:0]   dz_wide;

    always_comb begin
        alt_quot = alt_prod_reg[PROD_W-1:hci_pkg::ALT_RECIP_SHIFT];
        if (8'(alt_quot) > 8'(ALT_ROWS - 2)) begin
            zi_next = ALT_IDX_W'(ALT_ROWS - 2);
        end else begin
            zi_next = ALT_IDX_W'(alt_quot);
        end
        rcell_base = 18'(zi_next) * 18'(hci_pkg::ALT_STEP);
        dz_wide    = $signed(18'(alt_s2_reg)) - $signed(rcell_base);
    end

    // stage three
    logic [ALT_IDX_W-1:0]             zi_reg;
    logic [DEW_IDX_W-1:0]             di_reg;
    logic signed [hci_pkg::OFF_W-1:0] dz_reg;
    logic signed [hci_pkg::OFF_W-1:0] dd_reg;

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            zi_reg <= zi_next;
            di_reg <= di_s2_reg;
            dz_reg <= dz_wide[hci_pkg::OFF_W-1:0];
            dd_reg <= dd_s2_reg;
        end
    end

    assign zi = zi_reg;
    assign di = di_reg;
    assign dz = dz_reg;
    assign dd = dd_reg;

endmodule

`default_nettype wire

// ===== rtl/hci_rom.sv =====
// ----------------------------------------------------------------------------
// hci_rom
// Synchronous grid ROM: reads the four corners of the selected cell into
// a registered output.
// ----------------------------------------------------------------------------
`default_nettype none

module hci_rom #(
    parameter int ALT_ROWS = hci_pkg::ALT_ROWS_DEF,
    parameter int DEW_COLS = hci_pkg::DEW_COLS_DEF,
    localparam int ALT_IDX_W = $clog2(ALT_ROWS),
    localparam int DEW_IDX_W = $clog2(DEW_COLS)
) (
    input  wire logic                 aclk,
    input  wire logic                 en,
    input  wire logic [ALT_IDX_W-1:0] zi,
    input  wire logic [DEW_IDX_W-1:0] di,
    output hci_pkg::corner_t          corners
);

    logic [7:0]       row_lo;
    logic [7:0]       row_hi;
    logic [7:0]       col_lo;
    logic [7:0]       col_hi;
    hci_pkg::corner_t corners_reg;

    // corner addresses, clamped to the stored grid inside the lookup
    always_comb begin
        row_lo = 8'(zi);
        row_hi = 8'(zi) + 8'd1;
        col_lo = 8'(di);
        col_hi = 8'(di) + 8'd1;
    end

    // registered read
    always_ff @(posedge aclk) begin
        if (en) begin
            corners_reg.c00 <= hci_pkg::grid_at(row_lo, col_lo);
            corners_reg.c10 <= hci_pkg::grid_at(row_hi, col_lo);
            corners_reg.c01 <= hci_pkg::grid_at(row_lo, col_hi);
            corners_reg.c11 <= hci_pkg::grid_at(row_hi, col_hi);
        end
    end

    assign corners = corners_reg;

endmodule

`default_nettype wire

// ===== rtl/humidity_correction_interpolator.sv =====
// ----------------------------------------------------------------------------
// humidity_correction_interpolator
// Throughput: one transfer per cycle while m_tready is high; each stage holds
// its item while the next one is full, so input is still taken while a result
// waits at the output, as long as some stage is empty.
// Reset clears the stage valid bits only; the grid is a ROM.
// ----------------------------------------------------------------------------
`default_nettype none

module humidity_correction_interpolator #(
    parameter int ALT_ROWS = hci_pkg::ALT_ROWS_DEF,
    parameter int DEW_COLS = hci_pkg::DEW_COLS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // [14:0] dew_point, [29:15] altitude, [31:30] zero
    input  wire logic [hci_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // [15:0] correction
    output logic [hci_pkg::M_TDATA_W-1:0]      m_tdata
);

    localparam int ALT_IDX_W = $clog2(ALT_ROWS);
    localparam int DEW_IDX_W = $clog2(DEW_COLS);
    localparam int NST       = hci_pkg::NUM_STAGES;
    localparam int U_W       = hci_pkg::ACC_W - hci_pkg::ROUND_SHIFT;
    localparam int QP_W      = 41;

    typedef logic signed [hci_pkg::ACC_W-1:0] acc_t;

    // stage valid bits and per-stage load enables
    logic [NST-1:0] vld_reg;
    logic [NST-1:0] vld_next;
    logic [NST-1:0] vld_shift;
    logic [NST-1:0] en;

    always_comb begin
        en[NST-1] = !vld_reg[NST-1] || m_tready;
        for (int k = NST - 2; k >= 0; k--) begin
            en[k] = !vld_reg[k] || en[k+1];
        end
        vld_shift = {vld_reg[NST-2:0], s_tvalid};
        vld_next  = (en & vld_shift) | (~en & vld_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign s_tready = en[0];
    assign m_tvalid = vld_reg[NST-1];

    // cell selection, stages one to three
    logic [ALT_IDX_W-1:0]             cell_zi;
    logic [DEW_IDX_W-1:0]             cell_di;
    logic signed [hci_pkg::OFF_W-1:0] cell_dz;
    logic signed [hci_pkg::OFF_W-1:0] cell_dd;

    hci_cell #(
        .ALT_ROWS (ALT_ROWS),
        .DEW_COLS (DEW_COLS)
    ) u_cell (
        .aclk      (aclk),
        .en        (en[2:0]),
        .dew_point (s_tdata[hci_pkg::DEW_W-1:0]),
        .altitude  (s_tdata[hci_pkg::DEW_W+hci_pkg::ALT_W-1:hci_pkg::DEW_W]),
        .zi        (cell_zi),
        .di        (cell_di),
        .dz        (cell_dz),
        .dd        (cell_dd)
    );

    // stage four: corner read, offsets carried alongside
    hci_pkg::corner_t corners;

    hci_rom #(
        .ALT_ROWS (ALT_ROWS),
        .DEW_COLS (DEW_COLS)
    ) u_rom (
        .aclk    (aclk),
        .en      (en[3]),
        .zi      (cell_zi),
        .di      (cell_di),
        .corners (corners)
    );

    logic signed [hci_pkg::OFF_W-1:0] dz_s4_reg;
    logic signed [hci_pkg::OFF_W-1:0] dd_s4_reg;

    always_ff @(posedge aclk) begin
        if (en[3]) begin
            dz_s4_reg <= cell_dz;
            dd_s4_reg <= cell_dd;
        end
    end

    // stage five: corner differences and first products
    logic signed [7:0]  diff_a;
    logic signed [7:0]  diff_b;
    logic signed [8:0]  diff_e;
    logic signed [23:0] p1_next;
    logic signed [23:0] p2_next;
    logic signed [31:0] p3_next;

    always_comb begin
        diff_a  = $signed(8'(corners.c10) - 8'(corners.c00));
        diff_b  = $signed(8'(corners.c01) - 8'(corners.c00));
        diff_e  = $signed(9'(corners.c00) - 9'(corners.c10) - 9'(corners.c01)
                          + 9'(corners.c11));
        p1_next = diff_a * dz_s4_reg;
        p2_next = diff_b * dd_s4_reg;
        p3_next = dz_s4_reg * dd_s4_reg;
    end

    hci_pkg::entry_t    c00_reg;
    logic signed [8:0]  e_reg;
    logic signed [23:0] p1_reg;
    logic signed [23:0] p2_reg;
    logic signed [31:0] p3_reg;

    always_ff @(posedge aclk) begin
        if (en[4]) begin
            c00_reg <= corners.c00;
            e_reg   <= diff_e;
            p1_reg  <= p1_next;
            p2_reg  <= p2_next;
            p3_reg  <= p3_next;
        end
    end

    // stage six: scale each term to the common fixed point
    logic signed [QP_W-1:0] t3_wide;
    acc_t t0_reg;
    acc_t t1_reg;
    acc_t t2_reg;
    acc_t t3_reg;

    assign t3_wide = e_reg * p3_reg;

    always_ff @(posedge aclk) begin
        if (en[5]) begin
            t0_reg <= acc_t'(c00_reg) * acc_t'(hci_pkg::BASE_SCALE);
            t1_reg <= acc_t'(p1_reg) <<< hci_pkg::DEW_SHIFT;
            t2_reg <= acc_t'(p2_reg) * acc_t'(hci_pkg::ALT_STEP);
            t3_reg <= acc_t'(t3_wide);
        end
    end

    // stage seven: pairwise sums
    acc_t s01_reg;
    acc_t s23_reg;

    always_ff @(posedge aclk) begin
        if (en[6]) begin
            s01_reg <= t0_reg + t1_reg;
            s23_reg <= t2_reg + t3_reg;
        end
    end

    // stage eight: clamp at zero, round bias, divide by 256
    acc_t           v_sum;
    acc_t           v_bias;
    logic [U_W-1:0] u_next;
    logic [U_W-1:0] u_reg;

    always_comb begin
        v_sum  = s01_reg + s23_reg;
        v_bias = v_sum + acc_t'(hci_pkg::ROUND_BIAS);
        if (v_sum < 0) begin
            u_next = '0;
        end else begin
            u_next = v_bias[hci_pkg::ACC_W-1:hci_pkg::ROUND_SHIFT];
        end
    end

    always_ff @(posedge aclk) begin
        if (en[7]) begin
            u_reg <= u_next;
        end
    end

    // stage nine: saturation flag and divide by five through a reciprocal
    logic            sat_reg;
    logic [QP_W-1:0] qprod_reg;

    always_ff @(posedge aclk) begin
        if (en[8]) begin
            sat_reg   <= u_reg > U_W'(hci_pkg::QUOT_LIMIT);
            qprod_reg <= QP_W'(u_reg[18:0]) * QP_W'(hci_pkg::DIV5_RECIP);
        end
    end

    // stage ten: output register
    logic [hci_pkg::OUT_W-1:0] corr_reg;

    always_ff @(posedge aclk) begin
        if (en[9]) begin
            if (sat_reg) begin
                corr_reg <= hci_pkg::OUT_W'(hci_pkg::OUT_MAX);
            end else begin
                corr_reg <= qprod_reg[hci_pkg::DIV5_SHIFT+hci_pkg::OUT_W-1:hci_pkg::DIV5_SHIFT];
            end
        end
    end

    assign m_tdata = corr_reg;

`ifndef NO_ASSERTIONS
    // input may only stall when every stage holds an item
    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (&vld_reg))
        else $error("input stalled with an empty stage");

    // an accepted transfer occupies the first stage next cycle
    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> vld_reg[0])
        else $error("accepted transfer lost at first stage");

    // selected cell always lies inside the grid
    a_cell_in_grid: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[2] |-> ((32'(cell_di) <= DEW_COLS - 2) && (32'(cell_zi) <= ALT_ROWS - 2)))
        else $error("cell index beyond grid");

    // an overflowing quotient leaves as the saturated value
    a_saturate: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg[8] && en[9] && sat_reg) |=> (m_tdata == hci_pkg::OUT_W'(hci_pkg::OUT_MAX)))
        else $error("saturation not applied");
`endif

endmodule

`default_nettype wire
